[rtl/core/est_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// est_pkg
// Shared sizes, item types, action and status codes and sequencer states
// for the event subscriber table.
// ----------------------------------------------------------------------------
package est_pkg;

	localparam int EVENTS      = 256;
	localparam int SUBSCRIBERS = 8;
	localparam int ID_BITS     = 8;

	localparam int EV_BITS    = (EVENTS > 1) ? $clog2(EVENTS) : 1;
	localparam int SL_BITS    = (SUBSCRIBERS > 1) ? $clog2(SUBSCRIBERS) : 1;
	localparam int CNT_BITS   = $clog2(SUBSCRIBERS + 1);
	localparam int ID_W       = (ID_BITS < 8) ? ID_BITS : 8;
	localparam int SLOT_DEPTH = EVENTS << SL_BITS;

	localparam logic [1:0] ACT_ADD        = 2'd0;
	localparam logic [1:0] ACT_REMOVE     = 2'd1;
	localparam logic [1:0] ACT_REMOVE_ALL = 2'd2;
	localparam logic [1:0] ACT_LIST       = 2'd3;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_INVALID = 2'd1;
	localparam logic [1:0] STAT_FULL    = 2'd2;

	typedef struct packed {
		logic [1:0] action;
		logic [9:0] event_req;
		logic [7:0] subscriber;
	} req_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] listed_subscriber;
		logic [3:0] subscriber_count;
		logic       event_used;
		logic       last;
	} rsp_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CNT_RD,
		ST_CNT_GET,
		ST_SLOT_RD,
		ST_SLOT_CMP,
		ST_ROW_END,
		ST_LIST_RD,
		ST_LIST_GET,
		ST_EMIT
	} est_state_t;

endpackage

[rtl/core/event_subscriber_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_subscriber_table
// Per-event packed lists of subscriber ids with add, remove, remove-all
// and list actions, walked one slot at a time by a small sequencer.
// ----------------------------------------------------------------------------
// Each event row lives in a slot memory (one id per word) and a count memory
// (one fill count per row); a row flag per event, cleared at reset, makes an
// untouched row read as empty, so there is no clearing pass after reset. Slots
// at or past a row's count are never read. One item is taken at a time and
// req_stall is high until its final result sits in the output register.
// Add and remove walk the row's slots one at a time, and a list gives one
// result per subscriber. Remove-all of a nonzero id visits every row in
// turn; remove-all of id 0 visits no row and only reports the requested
// row's count. While rsp_stall holds the output register, the sequencer
// waits in ST_EMIT.
module event_subscriber_table (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  est_pkg::req_item_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output est_pkg::rsp_item_t rsp
);
	import est_pkg::*;

	est_state_t state_q, state_d;

	// sequencer registers
	logic [EV_BITS-1:0]  row_q;
	logic [CNT_BITS-1:0] slot_q;
	logic [CNT_BITS-1:0] n_q;
	logic                found_q;
	logic                final_q;
	logic [EVENTS-1:0]   row_valid_q;
	logic                rsp_valid_q;

	// item payload
	logic [1:0]          act_q;
	logic [ID_W-1:0]     id_q;
	logic [EV_BITS-1:0]  ev_q;
	logic                ev_ok_q;
	rsp_item_t           res_q;
	rsp_item_t           rsp_q;

	// memories
	logic [ID_W-1:0]     slot_mem [SLOT_DEPTH];
	logic [CNT_BITS-1:0] cnt_mem  [EVENTS];
	logic [ID_W-1:0]     slot_rd_q;
	logic [CNT_BITS-1:0] cnt_rd_q;
	logic                valid_rd_q;

	logic                        slot_we;
	logic [EV_BITS+SL_BITS-1:0]  slot_waddr;
	logic [ID_W-1:0]             slot_wdata;
	logic [EV_BITS+SL_BITS-1:0]  slot_raddr;
	logic                        cnt_we;
	logic [CNT_BITS-1:0]         cnt_wdata;

	logic                accept;
	logic                emit_load;
	logic                res_set;
	rsp_item_t           res_d;
	logic [ID_W-1:0]     id_in;
	logic [EV_BITS-1:0]  ev_in;
	logic                ev_ok_in;
	logic [CNT_BITS-1:0] n_rd;
	logic [CNT_BITS-1:0] slot_prev;
	logic                at_last_slot;

	function automatic rsp_item_t make_res(logic [1:0] st, logic [ID_W-1:0] id,
		logic [CNT_BITS-1:0] n, logic lst);
		rsp_item_t             r;
		logic [CNT_BITS+3:0]   wide;
		wide                = (CNT_BITS + 4)'(n);
		r.status            = st;
		r.listed_subscriber = 8'(id);
		r.subscriber_count  = (wide > (CNT_BITS + 4)'(15)) ? 4'd15 : 4'(wide);
		r.event_used        = (n != '0);
		r.last              = lst;
		return r;
	endfunction

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign id_in    = req.subscriber[ID_W-1:0];
	assign ev_in    = EV_BITS'(req.event_req);
	assign ev_ok_in = (11'(req.event_req) < 11'(EVENTS));

	assign n_rd         = valid_rd_q ? cnt_rd_q : '0;
	assign slot_prev    = CNT_BITS'(slot_q - 1'b1);
	assign at_last_slot = (slot_q == CNT_BITS'(n_q - 1'b1));
	assign slot_raddr   = {row_q, slot_q[SL_BITS-1:0]};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req.action != ACT_REMOVE_ALL && !ev_ok_in) begin
						state_d = ST_EMIT;
					end else begin
						state_d = ST_CNT_RD;
					end
				end
			end
			ST_CNT_RD: state_d = ST_CNT_GET;
			ST_CNT_GET: begin
				if (final_q) begin
					state_d = ST_EMIT;
				end else if (act_q == ACT_LIST) begin
					state_d = (n_rd == '0) ? ST_EMIT : ST_LIST_RD;
				end else if (n_rd == '0 || id_q == '0) begin
					state_d = ST_ROW_END;
				end else begin
					state_d = ST_SLOT_RD;
				end
			end
			ST_SLOT_RD:  state_d = ST_SLOT_CMP;
			ST_SLOT_CMP: state_d = at_last_slot ? ST_ROW_END : ST_SLOT_RD;
			ST_ROW_END:  state_d = (act_q == ACT_REMOVE_ALL) ? ST_CNT_RD : ST_EMIT;
			ST_LIST_RD:  state_d = ST_LIST_GET;
			ST_LIST_GET: state_d = ST_EMIT;
			ST_EMIT: begin
				if (!rsp_valid_q || !rsp_stall) begin
					state_d = res_q.last ? ST_IDLE : ST_LIST_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs: memory writes and result building
	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = {row_q, slot_prev[SL_BITS-1:0]};
		slot_wdata = slot_rd_q;
		cnt_we     = 1'b0;
		cnt_wdata  = CNT_BITS'(n_q - 1'b1);
		res_set    = 1'b0;
		res_d      = make_res(STAT_OK, id_q, n_q, 1'b1);
		emit_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && req.action != ACT_REMOVE_ALL && !ev_ok_in) begin
					res_set = 1'b1;
					res_d   = make_res(STAT_INVALID, id_in, '0, 1'b1);
				end
			end
			ST_CNT_GET: begin
				if (final_q) begin
					res_set = 1'b1;
					res_d   = make_res(STAT_OK, id_q, ev_ok_q ? n_rd : '0, 1'b1);
				end else if (act_q == ACT_LIST && n_rd == '0) begin
					res_set = 1'b1;
					res_d   = make_res(STAT_OK, '0, '0, 1'b1);
				end
			end
			ST_SLOT_CMP: begin
				// once the id is found, every later slot moves down by one
				slot_we = found_q && (act_q != ACT_ADD);
			end
			ST_ROW_END: begin
				case (act_q)
					ACT_ADD: begin
						res_set = 1'b1;
						if (id_q == '0 || found_q) begin
							res_d = make_res(STAT_OK, id_q, n_q, 1'b1);
						end else if (n_q == CNT_BITS'(SUBSCRIBERS)) begin
							res_d = make_res(STAT_FULL, id_q, n_q, 1'b1);
						end else begin
							slot_we    = 1'b1;
							slot_waddr = {row_q, n_q[SL_BITS-1:0]};
							slot_wdata = id_q;
							cnt_we     = 1'b1;
							cnt_wdata  = CNT_BITS'(n_q + 1'b1);
							res_d      = make_res(STAT_OK, id_q, cnt_wdata, 1'b1);
						end
					end
					ACT_REMOVE: begin
						res_set = 1'b1;
						cnt_we  = found_q;
						res_d   = make_res(STAT_OK, id_q, found_q ? cnt_wdata : n_q, 1'b1);
					end
					ACT_REMOVE_ALL: begin
						cnt_we = found_q;
					end
					default: begin
						res_set = 1'b0;
					end
				endcase
			end
			ST_LIST_GET: begin
				res_set = 1'b1;
				res_d   = make_res(STAT_OK, slot_rd_q, n_q, at_last_slot);
			end
			ST_EMIT: begin
				emit_load = !rsp_valid_q || !rsp_stall;
			end
			default: begin
				res_set = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_q       <= '0;
			slot_q      <= '0;
			n_q         <= '0;
			found_q     <= 1'b0;
			final_q     <= 1'b0;
			row_valid_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cnt_we) begin
				row_valid_q[row_q] <= 1'b1;
			end
			if (emit_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						final_q <= (req.action == ACT_REMOVE_ALL) && (id_in == '0);
						if (req.action == ACT_REMOVE_ALL && id_in != '0) begin
							row_q <= '0;
						end else begin
							row_q <= ev_in;
						end
					end
				end
				ST_CNT_GET: begin
					n_q     <= n_rd;
					slot_q  <= '0;
					found_q <= 1'b0;
				end
				ST_SLOT_CMP: begin
					if (!found_q && slot_rd_q == id_q) begin
						found_q <= 1'b1;
					end
					slot_q <= CNT_BITS'(slot_q + 1'b1);
				end
				ST_ROW_END: begin
					if (act_q == ACT_REMOVE_ALL) begin
						// after the last row, read back the requested row's count
						if (row_q == EV_BITS'(EVENTS - 1)) begin
							row_q   <= ev_q;
							final_q <= 1'b1;
						end else begin
							row_q <= EV_BITS'(row_q + 1'b1);
						end
					end
				end
				ST_LIST_GET: begin
					slot_q <= CNT_BITS'(slot_q + 1'b1);
				end
				default: begin
					found_q <= found_q;
				end
			endcase
		end
	end

	// item payload and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q   <= req.action;
			id_q    <= id_in;
			ev_q    <= ev_in;
			ev_ok_q <= ev_ok_in;
		end
		if (res_set) begin
			res_q <= res_d;
		end
		if (emit_load) begin
			rsp_q <= res_q;
		end
	end

	// slot memory, one id per word
	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_waddr] <= slot_wdata;
		end
		slot_rd_q <= slot_mem[slot_raddr];
	end

	// count memory, one fill count per row
	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[row_q] <= cnt_wdata;
		end
		cnt_rd_q   <= cnt_mem[row_q];
		valid_rd_q <= row_valid_q[row_q];
	end

endmodule
